// ===== rtl/ntsg_pkg.sv =====
// Package for the neighbour table with sequence-gap EWMA link estimate.
// Holds table sizing, field widths, status codes and the table entry type.
// No dependencies.
package ntsg_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam int ADDR_W  = 16;
    localparam int SEQ_W   = 8;
    localparam int ATTR_W  = 16;
    localparam int AVG_W   = 16;
    localparam int STAT_W  = 2;
    localparam int SLOT_W  = 4;

    // 8.8 fixed point EWMA constants
    localparam int EWMA_UNITY = 'h100;
    localparam int EWMA_ALPHA = 'h040;
    localparam int EWMA_KEEP  = EWMA_UNITY - EWMA_ALPHA;
    localparam int EWMA_SHIFT = $clog2(EWMA_UNITY);
    localparam int PROD_W     = 24;

    localparam logic [STAT_W-1:0] STATUS_UPDATED  = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_INSERTED = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL     = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SEQ_W-1:0]  seq;
        logic [AVG_W-1:0]  avg;
        logic [ATTR_W-1:0] strength;
        logic [ATTR_W-1:0] quality;
    } entry_t;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
        logic [IDX_W+SLOT_W-1:0] wide;
        wide = {{SLOT_W{1'b0}}, idx};
        return wide[SLOT_W-1:0];
    endfunction

endpackage

// ===== rtl/ntsg_req_if.sv =====
// Request channel: one received broadcast per transaction.
// Depends on ntsg_pkg for field widths.
interface ntsg_req_if;
    import ntsg_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] sender_address;
    logic [SEQ_W-1:0]  sequence_number;
    logic [ATTR_W-1:0] signal_strength;
    logic [ATTR_W-1:0] link_quality;

    modport source (output valid, sender_address, sequence_number,
                    signal_strength, link_quality, input ready);
    modport sink   (input valid, sender_address, sequence_number,
                    signal_strength, link_quality, output ready);
endinterface

// ===== rtl/ntsg_rsp_if.sv =====
// Response channel: status, slot, gap and average for each broadcast.
// Depends on ntsg_pkg for field widths.
interface ntsg_rsp_if;
    import ntsg_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [SEQ_W-1:0]  gap_seen;
    logic [AVG_W-1:0]  average_gap;

    modport source (output valid, status, slot, gap_seen, average_gap, input ready);
    modport sink   (input valid, status, slot, gap_seen, average_gap, output ready);
endinterface

// ===== rtl/neighbor_table_seqno_gap_ewma.sv =====
// Top level of the neighbour table with sequence-gap EWMA link estimate.
// Depends on ntsg_pkg, ntsg_req_if, ntsg_rsp_if and ntsg_table.

// One transaction on req is one received broadcast; exactly one transaction
// on rsp follows for it. The stored addresses are scanned in insertion order,
// one slot per cycle through the single read port of the table, until the
// address is found or the last stored slot is passed (new entry or table
// full). req.ready is high only between items; a finished result moves to
// the output register once that is free, and while it waits there the next
// request is accepted. Entries are never removed; a full table drops the
// packet with status full and zero fields.
module neighbor_table_seqno_gap_ewma
(
    input  logic        clk,
    input  logic        rst_n,
    ntsg_req_if.sink    req,
    ntsg_rsp_if.source  rsp
);
    import ntsg_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_INSERT = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    logic [ATTR_W-1:0] strength_reg, strength_next;
    logic [ATTR_W-1:0] quality_reg, quality_next;

    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic [SEQ_W-1:0]  res_gap_reg, res_gap_next;
    logic [AVG_W-1:0]  res_avg_reg, res_avg_next;

    logic              out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] out_status_reg, out_status_next;
    logic [SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic [SEQ_W-1:0]  out_gap_reg, out_gap_next;
    logic [AVG_W-1:0]  out_avg_reg, out_avg_next;

    entry_t            rd_data;
    entry_t            wr_data;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;

    logic [SEQ_W-1:0]  gap;
    logic [PROD_W-1:0] keep_prod;
    logic [AVG_W-1:0]  avg_new;
    logic              idx_last;
    logic              table_full;
    logic              out_free;

    ntsg_table u_table
    (
        .clk     (clk),
        .rd_idx  (idx_next),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (wr_data)
    );

    // Shared update unit: gap and EWMA from the entry currently read out
    always_comb
    begin
        gap       = seq_reg - rd_data.seq;
        keep_prod = PROD_W'(rd_data.avg) * PROD_W'(EWMA_KEEP);
        avg_new   = AVG_W'(PROD_W'(gap) * PROD_W'(EWMA_ALPHA)
                    + PROD_W'(keep_prod[PROD_W-1:EWMA_SHIFT]));
    end

    assign idx_last   = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;
    assign table_full = count_reg == CNT_W'(TABLE_ENTRIES);
    assign out_free   = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        addr_next       = addr_reg;
        seq_next        = seq_reg;
        strength_next   = strength_reg;
        quality_next    = quality_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_gap_next    = res_gap_reg;
        res_avg_next    = res_avg_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_gap_next    = out_gap_reg;
        out_avg_next    = out_avg_reg;
        wr_en           = 1'b0;
        wr_idx          = idx_reg;
        wr_data         = '{addr: addr_reg, seq: seq_reg, avg: avg_new,
                            strength: strength_reg, quality: quality_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    addr_next     = req.sender_address;
                    seq_next      = req.sequence_number;
                    strength_next = req.signal_strength;
                    quality_next  = req.link_quality;
                    idx_next      = '0;
                    state_next    = (count_reg == '0) ? S_INSERT : S_SCAN;
                end
            end
            S_SCAN:
            begin
                // rd_data holds the entry at idx_reg
                if (rd_data.addr == addr_reg)
                begin
                    wr_en           = 1'b1;
                    res_status_next = STATUS_UPDATED;
                    res_slot_next   = slot_of(idx_reg);
                    res_gap_next    = gap;
                    res_avg_next    = avg_new;
                    state_next      = S_DONE;
                end
                else if (idx_last)
                begin
                    state_next = S_INSERT;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_INSERT:
            begin
                if (table_full)
                begin
                    res_status_next = STATUS_FULL;
                    res_slot_next   = '0;
                    res_gap_next    = '0;
                    res_avg_next    = '0;
                end
                else
                begin
                    // new entry: gap of one against an average of unity
                    wr_en           = 1'b1;
                    wr_idx          = count_reg[IDX_W-1:0];
                    wr_data.avg     = AVG_W'(EWMA_UNITY);
                    count_next      = count_reg + CNT_W'(1);
                    res_status_next = STATUS_INSERTED;
                    res_slot_next   = slot_of(count_reg[IDX_W-1:0]);
                    res_gap_next    = SEQ_W'(1);
                    res_avg_next    = AVG_W'(EWMA_UNITY);
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = res_slot_reg;
                    out_gap_next    = res_gap_reg;
                    out_avg_next    = res_avg_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        seq_reg        <= seq_next;
        strength_reg   <= strength_next;
        quality_reg    <= quality_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_gap_reg    <= res_gap_next;
        res_avg_reg    <= res_avg_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_gap_reg    <= out_gap_next;
        out_avg_reg    <= out_avg_next;
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.slot        = out_slot_reg;
    assign rsp.gap_seen    = out_gap_reg;
    assign rsp.average_gap = out_avg_reg;

endmodule

// ===== rtl/ntsg_table.sv =====
// Neighbour table storage: one write port, one registered read port.
// Depends on ntsg_pkg for entry_t and IDX_W.
module ntsg_table
(
    input  logic                      clk,
    input  logic [ntsg_pkg::IDX_W-1:0] rd_idx,
    output ntsg_pkg::entry_t          rd_data,
    input  logic                      wr_en,
    input  logic [ntsg_pkg::IDX_W-1:0] wr_idx,
    input  ntsg_pkg::entry_t          wr_data
);
    import ntsg_pkg::*;

    entry_t mem [TABLE_ENTRIES];
    entry_t rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        rd_reg <= mem[rd_idx];
    end

    assign rd_data = rd_reg;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for the neighbour table with sequence-gap EWMA link estimate.
// Holds a small link scoreboard class and the driving tasks; needs ntsg_pkg,
// ntsg_req_if, ntsg_rsp_if and the neighbor_table_seqno_gap_ewma RTL.
module tb_top;
    import ntsg_pkg::*;

    localparam int LIMIT_CYCLES = 300000;
    localparam int DRAIN_CYCLES = 30;
    localparam int PHASE_ITEMS  = 220;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic [SEQ_W-1:0]  gap_seen;
        logic [AVG_W-1:0]  average_gap;
    } link_report_t;

    class link_scoreboard;
        entry_t       neighbours[TABLE_ENTRIES];
        int unsigned  occupied;
        link_report_t awaited[$];
        int unsigned  failures;

        function new();
            occupied = 0;
            failures = 0;
        endfunction

        function void report(string what);
            if (failures < 40)
            begin
                $display("[%0t] ERROR: %s", $time, what);
            end
            failures++;
        endfunction

        // Table lookup and EWMA update for one accepted broadcast
        function void note_broadcast(logic [ADDR_W-1:0] addr, logic [SEQ_W-1:0] seq,
                                     logic [ATTR_W-1:0] strength,
                                     logic [ATTR_W-1:0] quality);
            int           hit;
            int unsigned  next_avg;
            link_report_t want;
            hit = -1;
            for (int i = 0; i < occupied; i++)
            begin
                if (hit < 0 && neighbours[i].addr == addr)
                begin
                    hit = i;
                end
            end
            if (hit < 0)
            begin
                if (occupied >= TABLE_ENTRIES)
                begin
                    awaited.push_back(link_report_t'{STATUS_FULL, '0, '0, '0});
                    return;
                end
                hit = occupied;
                occupied++;
                neighbours[hit].addr = addr;
                neighbours[hit].seq  = seq - 1'b1;
                neighbours[hit].avg  = AVG_W'(EWMA_UNITY);
                want.status = STATUS_INSERTED;
            end
            else
            begin
                want.status = STATUS_UPDATED;
            end
            neighbours[hit].strength = strength;
            neighbours[hit].quality  = quality;
            want.slot     = SLOT_W'(hit);
            want.gap_seen = seq - neighbours[hit].seq;
            next_avg = want.gap_seen * EWMA_ALPHA
                     + ((neighbours[hit].avg * EWMA_KEEP) >> EWMA_SHIFT);
            neighbours[hit].avg = AVG_W'(next_avg);
            neighbours[hit].seq = seq;
            want.average_gap = neighbours[hit].avg;
            awaited.push_back(want);
        endfunction

        function void check_result(link_report_t got);
            link_report_t want;
            if (awaited.size() == 0)
            begin
                report($sformatf("unexpected result status=%0d slot=%0d gap=%0d avg=%h",
                                 got.status, got.slot, got.gap_seen, got.average_gap));
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status)
            begin
                report($sformatf("status %0d, expected %0d", got.status, want.status));
            end
            if (got.slot !== want.slot)
            begin
                report($sformatf("slot %0d, expected %0d", got.slot, want.slot));
            end
            if (got.gap_seen !== want.gap_seen)
            begin
                report($sformatf("gap %0d, expected %0d", got.gap_seen, want.gap_seen));
            end
            if (got.average_gap !== want.average_gap)
            begin
                report($sformatf("average %h, expected %h",
                                 got.average_gap, want.average_gap));
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycles     = 0;
    int   send_idle  = 0;
    int   recv_stall = 0;

    link_scoreboard board = new();

    ntsg_req_if req();
    ntsg_rsp_if rsp();

    neighbor_table_seqno_gap_ewma u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver: ready changes at the falling edge only
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            board.check_result(link_report_t'{rsp.status, rsp.slot,
                                              rsp.gap_seen, rsp.average_gap});
        end
    end

    task automatic send_broadcast(logic [ADDR_W-1:0] addr, logic [SEQ_W-1:0] seq,
                                  logic [ATTR_W-1:0] strength,
                                  logic [ATTR_W-1:0] quality);
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid           <= 1'b1;
        req.sender_address  <= addr;
        req.sequence_number <= seq;
        req.signal_strength <= strength;
        req.link_quality    <= quality;
        @(posedge clk);
        while (!req.ready)
        begin
            @(posedge clk);
        end
        board.note_broadcast(addr, seq, strength, quality);
    endtask

    // Drop valid first so the last transaction is not taken twice
    task automatic wait_drained();
        @(negedge clk);
        req.valid <= 1'b0;
        while (board.awaited.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Mostly known neighbours with plausible gaps, some unknown senders
    task automatic random_item();
        logic [ADDR_W-1:0] addr;
        logic [SEQ_W-1:0]  seq;
        logic [SEQ_W-1:0]  gap;
        int                pick;
        if (board.occupied == 0 || $urandom_range(99) < 12)
        begin
            addr = ADDR_W'($urandom);
            seq  = SEQ_W'($urandom);
        end
        else
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: gap = 8'd1;
                5:             gap = 8'd0;
                6:             gap = 8'hFF;
                7:             gap = SEQ_W'($urandom_range(5, 2));
                default:       gap = SEQ_W'($urandom);
            endcase
            pick = $urandom_range(board.occupied - 1);
            addr = board.neighbours[pick].addr;
            seq  = board.neighbours[pick].seq + gap;
        end
        send_broadcast(addr, seq, ATTR_W'($urandom), ATTR_W'($urandom));
    endtask

    initial
    begin
        int idle_of[4];
        int stall_of[4];
        int pick;
        idle_of  = '{0, 82, 0, 25};
        stall_of = '{0, 0, 82, 25};

        rst_n               = 1'b0;
        req.valid           = 1'b0;
        req.sender_address  = '0;
        req.sequence_number = '0;
        req.signal_strength = '0;
        req.link_quality    = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extreme addresses and sequence wrap, zero and 255 gaps
        send_broadcast(16'h0000, 8'h00, 16'h0000, 16'h0000);
        send_broadcast(16'h0000, 8'h00, 16'hFFFF, 16'h0000);
        send_broadcast(16'h0000, 8'hFF, 16'h0000, 16'hFFFF);
        send_broadcast(16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_broadcast(16'hFFFF, 8'h00, 16'h8001, 16'h7FFE);
        // fill the remaining slots, then hit a full table
        for (int i = 0; i < TABLE_ENTRIES - 2; i++)
        begin
            send_broadcast(16'h8000 >> i, 8'(i * 17), ATTR_W'($urandom),
                           ATTR_W'($urandom));
        end
        send_broadcast(16'hA5A5, 8'h00, 16'h1234, 16'h4321);
        send_broadcast(16'h5A5A, 8'hFF, 16'hFFFF, 16'h0000);
        // last slot: longest scan
        send_broadcast(16'h0004, 8'(13 * 17 + 3), 16'h0001, 16'hFFFE);
        send_broadcast(16'h0000, 8'hFF, 16'h0000, 16'h0000);

        for (int phase = 0; phase < 4; phase++)
        begin
            // sender holds off until the table has answered everything
            wait_drained();
            send_idle  = idle_of[phase];
            recv_stall = stall_of[phase];
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(39) == 0)
                begin
                    // run of large gaps on one neighbour drives the average up
                    pick = $urandom_range(TABLE_ENTRIES - 1);
                    repeat (12)
                    begin
                        send_broadcast(board.neighbours[pick].addr,
                                       board.neighbours[pick].seq
                                       + 8'($urandom_range(255, 192)),
                                       ATTR_W'($urandom), ATTR_W'($urandom));
                    end
                    n += 11;
                end
                else
                begin
                    random_item();
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.awaited.size() != 0)
        begin
            board.report($sformatf("%0d results never arrived", board.awaited.size()));
        end
        if (board.failures == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
